@@ hw/rtl/wnm_pkg.sv @@
// ----------------------------------------------------------------------------
// Wildcard name matcher package
// Shared constants, types and helper functions of the wildcard name matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wnm_pkg;

  localparam int PAT_BYTES   = 32;
  localparam int MAX_PATTERN = 32;
  localparam int EFF_MAX     = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
  localparam int IDX_W       = $clog2(PAT_BYTES);
  localparam int LEN_W       = IDX_W + 1;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int WORDS       = PAT_BYTES / 8;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD = 3'd5;

  typedef enum logic [1:0] {
    PH_COMPARE,
    PH_SEEK,
    PH_SUFFIX
  } phase_t;

  typedef enum logic [1:0] {
    V_UNDECIDED,
    V_FALSE,
    V_TRUE
  } verdict_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
  } item_t;

  // Pattern information derived from the configuration registers.
  typedef struct packed {
    logic                           fold;
    logic [LEN_W-1:0]               len;
    logic [PAT_BYTES-1:0][7:0]      fold_bytes;
    logic [PAT_BYTES-1:0]           star;
    logic [PAT_BYTES-1:0]           qmark;
    logic [PAT_BYTES-1:0]           valid;
    logic [PAT_BYTES-1:0]           segend;
    logic [PAT_BYTES-1:0]           wildlen;
  } pat_info_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] onehot_index(input logic [PAT_BYTES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < PAT_BYTES; i++) begin
      for (int j = 0; j < IDX_W; j++) begin
        if (((i >> j) & 1) == 1) begin
          idx[j] = idx[j] | v[i];
        end
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wnm_cfg.sv @@
// ----------------------------------------------------------------------------
// Wildcard name matcher configuration
// Holds the pattern registers and registers the pattern information derived
// from them: effective length, wildcard masks, segment ends and folded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_cfg
  import wnm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      restart,
  output pat_info_t                 pat
);

  logic [WORDS-1:0][63:0] words_r;
  logic [5:0]             len_r;
  logic                   fold_r;
  pat_info_t              pat_r;
  pat_info_t              pat_nxt;

  logic [PAT_BYTES-1:0][7:0] bytes;
  logic [LEN_W-1:0]          n;
  logic [PAT_BYTES-1:0]      lt_n;
  logic [PAT_BYTES-1:0]      zero_m;
  logic [PAT_BYTES-1:0]      zero_oh;
  logic [PAT_BYTES-1:0]      lt_len;
  logic [PAT_BYTES-1:0]      wild;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
      len_r   <= '0;
      fold_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT0: words_r[0] <= cfg_data;
        REG_PAT1: words_r[1] <= cfg_data;
        REG_PAT2: words_r[2] <= cfg_data;
        REG_PAT3: words_r[3] <= cfg_data;
        REG_LEN:  len_r      <= cfg_data[5:0];
        REG_FOLD: fold_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = cfg_we && (cfg_index <= REG_FOLD);
  end

  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      bytes[i] = words_r[i / 8][(i % 8) * 8 +: 8];
    end
    pat_nxt.fold = fold_r;
    n = (len_r > 6'(EFF_MAX)) ? LEN_W'(EFF_MAX) : LEN_W'(len_r);
    for (int i = 0; i < PAT_BYTES; i++) begin
      lt_n[i]   = LEN_W'(i) < n;
      zero_m[i] = (bytes[i] == 8'h00) && lt_n[i];
      wild[i]   = (bytes[i] == CH_STAR) || (bytes[i] == CH_QMARK);
      pat_nxt.fold_bytes[i] = fold_byte(bytes[i], fold_r);
      pat_nxt.star[i]       = bytes[i] == CH_STAR;
      pat_nxt.qmark[i]      = bytes[i] == CH_QMARK;
    end
    zero_oh = zero_m & (~zero_m + PAT_BYTES'(1));
    if (zero_m == '0) begin
      lt_len      = lt_n;
      pat_nxt.len = n;
    end else begin
      lt_len      = zero_oh - PAT_BYTES'(1);
      pat_nxt.len = {1'b0, onehot_index(zero_oh)};
    end
    pat_nxt.valid   = ~wild & lt_len;
    pat_nxt.wildlen = wild & lt_len;
    pat_nxt.segend  = pat_nxt.valid & ~(pat_nxt.valid >> 1);
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  assign pat = pat_r;

endmodule

`default_nettype wire

@@ hw/rtl/wnm_core.sv @@
// ----------------------------------------------------------------------------
// Wildcard name matcher core
// Matching state for one name. Segment search uses a bit-parallel shift-and
// vector over pattern positions, updated once per name byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_core
  import wnm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       restart,
  input  wire pat_info_t  pat,
  input  wire logic       proc_valid,
  input  wire item_t      proc_item,
  output logic            matched
);

  logic [LEN_W-1:0]     pat_pos_r, pat_pos_nxt;
  phase_t               phase_r, phase_nxt;
  verdict_t             verdict_r, verdict_nxt;
  logic [PAT_BYTES-1:0] act_r, act_nxt;

  logic [7:0]           b_f;
  logic [PAT_BYTES-1:0] eq;
  logic [PAT_BYTES-1:0] pos_oh;
  logic [PAT_BYTES-1:0] ge;
  logic [PAT_BYTES-1:0] open_m;
  logic [PAT_BYTES-1:0] q_oh;
  logic [PAT_BYTES-1:0] above_q;
  logic [PAT_BYTES-1:0] start;
  logic [PAT_BYTES-1:0] base;
  logic [PAT_BYTES-1:0] act_new;
  logic [PAT_BYTES-1:0] hit_vec;
  logic                 hit;
  logic [LEN_W-1:0]     hit_next;
  logic                 to_seek;
  logic                 pos_lt_len;
  logic [IDX_W-1:0]     pos_idx;
  logic                 suffix_ok;

  always_comb begin
    b_f        = fold_byte(proc_item.name_byte, pat.fold);
    pos_lt_len = pat_pos_r < pat.len;
    pos_idx    = pat_pos_r[IDX_W-1:0];
    pos_oh     = (pat_pos_r < LEN_W'(PAT_BYTES)) ? (PAT_BYTES'(1) << pos_idx) : '0;
    for (int i = 0; i < PAT_BYTES; i++) begin
      eq[i] = pat.fold_bytes[i] == b_f;
      ge[i] = LEN_W'(i) >= pat_pos_r;
    end
    open_m   = pat.valid & ge;
    q_oh     = open_m & (~open_m + PAT_BYTES'(1));
    above_q  = ~(q_oh | (q_oh - PAT_BYTES'(1)));
    to_seek  = |(pat.wildlen & above_q);
    start    = (phase_r == PH_COMPARE) ? q_oh : pos_oh;
    base     = (phase_r == PH_COMPARE) ? '0 : act_r;
    act_new  = ((base << 1) | start) & eq & pat.valid;
    hit_vec  = act_new & pat.segend;
    hit      = |hit_vec;
    hit_next = {1'b0, onehot_index(hit_vec)} + LEN_W'(1);
    suffix_ok = |(act_r & pat.segend);
  end

  always_comb begin
    pat_pos_nxt = pat_pos_r;
    phase_nxt   = phase_r;
    verdict_nxt = verdict_r;
    act_nxt     = act_r;
    if (restart || (proc_valid && proc_item.kind)) begin
      pat_pos_nxt = '0;
      phase_nxt   = PH_COMPARE;
      verdict_nxt = V_UNDECIDED;
      act_nxt     = '0;
    end else if (proc_valid && proc_item.name_byte != 8'h00 && verdict_r == V_UNDECIDED) begin
      unique case (phase_r)
        PH_COMPARE: begin
          if (!pos_lt_len) begin
            verdict_nxt = V_FALSE;
          end else if (pat.qmark[pos_idx]) begin
            pat_pos_nxt = pat_pos_r + LEN_W'(1);
          end else if (pat.star[pos_idx]) begin
            if (open_m == '0) begin
              verdict_nxt = V_TRUE;
            end else if (!to_seek) begin
              pat_pos_nxt = {1'b0, onehot_index(q_oh)};
              phase_nxt   = PH_SUFFIX;
              act_nxt     = act_new;
            end else if (hit) begin
              pat_pos_nxt = hit_next;
              act_nxt     = '0;
            end else begin
              pat_pos_nxt = {1'b0, onehot_index(q_oh)};
              phase_nxt   = PH_SEEK;
              act_nxt     = act_new;
            end
          end else if (eq[pos_idx]) begin
            pat_pos_nxt = pat_pos_r + LEN_W'(1);
          end else begin
            verdict_nxt = V_FALSE;
          end
        end
        PH_SEEK: begin
          if (hit) begin
            pat_pos_nxt = hit_next;
            phase_nxt   = PH_COMPARE;
            act_nxt     = '0;
          end else begin
            act_nxt = act_new;
          end
        end
        PH_SUFFIX: begin
          act_nxt = act_new;
        end
        default: begin
          phase_nxt = PH_COMPARE;
        end
      endcase
    end
  end

  always_comb begin
    if (verdict_r != V_UNDECIDED) begin
      matched = verdict_r == V_TRUE;
    end else if (phase_r == PH_COMPARE) begin
      matched = !pos_lt_len;
    end else if (phase_r == PH_SUFFIX) begin
      matched = suffix_ok;
    end else begin
      matched = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_pos_r <= '0;
      phase_r   <= PH_COMPARE;
      verdict_r <= V_UNDECIDED;
      act_r     <= '0;
    end else begin
      pat_pos_r <= pat_pos_nxt;
      phase_r   <= phase_nxt;
      verdict_r <= verdict_nxt;
      act_r     <= act_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wildcard_name_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Wildcard name matcher unit
// Matches a streamed file name against a configured wildcard pattern and
// returns one verdict per name on its end transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_      slave      one name byte (tdata) or the end of a name (tuser)
//  out_     master     verdict of one name (tdata bit 0)
//  cfg_     write      pattern bytes, pattern length, case folding
//
//  One input transaction is taken every cycle unless the input stalls; the core updates its
//  shift-and vector once per name byte.
//  out_tvalid rises once the accepted end transaction has passed the
//  input register and the pipeline register into the output register.
//  Reset is synchronous and needs no clearing pass.
//  A held verdict stalls the next end transaction in the pipeline register;
//  the input stalls once both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_name_matcher_unit
  import wnm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] name_byte
  input  wire logic [0:0]           in_tuser,   // [0] kind
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [0] matched, [7:1] zero
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic      restart;
  pat_info_t pat;
  logic      matched;

  logic  s0_v_r, s1_v_r, out_v_r;
  item_t s0_r, s1_r;
  logic  out_matched_r;

  logic out_free, s1_fire, s1_ready, s0_ready;

  wnm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .pat       (pat)
  );

  wnm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .pat        (pat),
    .proc_valid (s1_fire),
    .proc_item  (s1_r),
    .matched    (matched)
  );

  always_comb begin
    out_free = !out_v_r || out_tready;
    s1_fire  = s1_v_r && (!s1_r.kind || out_free);
    s1_ready = !s1_v_r || s1_fire;
    s0_ready = !s0_v_r || s1_ready;
  end

  assign in_tready  = s0_ready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_matched_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_v_r <= in_tvalid;
      end
      if (s1_ready) begin
        s1_v_r <= s0_v_r;
      end
      if (s1_fire && s1_r.kind) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_tvalid) begin
      s0_r.kind      <= in_tuser[0];
      s0_r.name_byte <= in_tdata;
    end
    if (s1_ready && s0_v_r) begin
      s1_r <= s0_r;
    end
    if (s1_fire && s1_r.kind) begin
      out_matched_r <= matched;
    end
  end

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_v_r && s1_r.kind))
    else $error("verdict raised without an end transaction");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s0_v_r && s1_v_r && s1_r.kind && out_v_r && !out_tready))
    else $error("input stalled without a held verdict");

  a_verdict_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_matched_r)))
    else $error("held verdict changed");

endmodule

`default_nettype wire

@@ test/wildcard_name_matcher_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard name matcher unit testbench
// Streams file names into the matcher against a series of wildcard patterns
// and checks every verdict against an in-bench copy of the greedy matching
// rules. A short directed section covers empty, clamped and truncated
// patterns; the random section derives most names from the loaded pattern.
// ----------------------------------------------------------------------------

module wildcard_name_matcher_unit_tb;
  import wnm_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int QUIET_FROM  = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NAME_MAX    = 48;

  class verdict_scoreboard;
    logic [63:0] pat_word [4];
    logic [5:0]  len_reg;
    logic        fold_en;
    logic [7:0]  recent [32];
    int unsigned pos;
    phase_t      phase;
    int unsigned in_phase;
    verdict_t    verdict;
    logic        verdicts_due [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      len_reg = '0;
      fold_en = 1'b1;
      errors  = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      foreach (recent[i]) recent[i] = '0;
      pos      = 0;
      phase    = PH_COMPARE;
      in_phase = 0;
      verdict  = V_UNDECIDED;
    endfunction

    function logic [7:0] byte_at(int unsigned i);
      if (i >= PAT_BYTES) return 8'h00;
      return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function int unsigned active_len();
      int unsigned n;
      n = len_reg;
      if (n > EFF_MAX) n = EFF_MAX;
      for (int unsigned i = 0; i < n; i++) begin
        if (byte_at(i) == 8'h00) return i;
      end
      return n;
    endfunction

    function bit wild(logic [7:0] c);
      return c == CH_STAR || c == CH_QMARK;
    endfunction

    function logic [7:0] folded(logic [7:0] c);
      if (fold_en && c >= "a" && c <= "z") return c - 8'h20;
      return c;
    endfunction

    function int unsigned segment_len(int unsigned q, int unsigned n);
      int unsigned k;
      k = 0;
      while (q + k < n && !wild(byte_at(q + k))) k++;
      return k;
    endfunction

    function void shift_in(logic [7:0] b);
      for (int i = 0; i < 31; i++) recent[i] = recent[i + 1];
      recent[31] = b;
      if (in_phase < 32) in_phase++;
    endfunction

    function bit tail_matches(int unsigned q, int unsigned k);
      if (k > 32 || in_phase < k) return 1'b0;
      for (int unsigned i = 0; i < k; i++) begin
        if (folded(recent[32 - k + i]) != folded(byte_at(q + i))) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void try_bind(int unsigned n);
      int unsigned k;
      k = segment_len(pos, n);
      if (tail_matches(pos, k)) begin
        pos      = (pos + k) & 6'h3F;
        phase    = PH_COMPARE;
        in_phase = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[idx[1:0]] = val;
        REG_LEN: len_reg = val[5:0];
        REG_FOLD: fold_en = val[0];
        default: return;
      endcase
      restart();
    endfunction

    function void note_input(logic kind, logic [7:0] b);
      int unsigned n;
      int unsigned q;
      int unsigned k;
      logic [7:0]  c;
      logic        v;
      n = active_len();
      if (kind) begin
        if (verdict != V_UNDECIDED) v = (verdict == V_TRUE);
        else if (phase == PH_COMPARE) v = (pos >= n);
        else if (phase == PH_SUFFIX) v = tail_matches(pos, segment_len(pos, n));
        else v = 1'b0;
        verdicts_due.push_back(v);
        restart();
        return;
      end
      if (b == 8'h00 || verdict != V_UNDECIDED) return;
      case (phase)
        PH_COMPARE: begin
          if (pos >= n) begin
            verdict = V_FALSE;
            return;
          end
          c = byte_at(pos);
          if (c == CH_QMARK) begin
            pos++;
          end else if (c == CH_STAR) begin
            q = pos;
            while (q < n && wild(byte_at(q))) q++;
            if (q >= n) begin
              verdict = V_TRUE;
              return;
            end
            k = segment_len(q, n);
            pos = q;
            in_phase = 0;
            if (q + k < n) phase = PH_SEEK;
            else phase = PH_SUFFIX;
            shift_in(b);
            if (phase == PH_SEEK) try_bind(n);
          end else if (folded(c) != folded(b)) begin
            verdict = V_FALSE;
          end else begin
            pos++;
          end
        end
        PH_SEEK: begin
          shift_in(b);
          try_bind(n);
        end
        default: shift_in(b);
      endcase
    endfunction

    function void check_result(logic got);
      logic want;
      if (verdicts_due.size() == 0) begin
        if (errors < 10) $display("ERROR: verdict %0b arrived with none outstanding", got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      if (got !== want) begin
        if (errors < 10) begin
          $display("ERROR: verdict %0d: expected matched=%0b, got %0b", checked, want, got);
        end
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'h00;  // [7:0] name_byte
  logic [0:0]           in_tuser   = 1'b0;   // [0] kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [7:0]           out_tdata;           // [0] matched, [7:1] zero
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  verdict_scoreboard sb = new();

  logic [7:0]  pat_img [PAT_BYTES];
  int unsigned cfg_len;
  logic [7:0]  name_q [$];
  int unsigned items_sent = 0;
  int unsigned settings   = 0;
  int unsigned gap_pct    = 15;
  int unsigned stall_pct  = 15;
  int unsigned cycle_count = 0;

  wildcard_name_matcher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata[0]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (items_sent < QUIET_FROM && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
    case ($urandom_range(0, 11))
      0, 1:    return "a";
      2, 3:    return "b";
      4:       return "B";
      5, 6:    return ".";
      7:       return "z";
      8:       return "Z";
      9:       return 8'h60;
      10:      return 8'h7B;
      default: return 8'h40;
    endcase
  endfunction

  function automatic logic [7:0] pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return CH_STAR;
    if (r < 28) return CH_QMARK;
    if (r < 30) return 8'h00;
    if (r < 34) return 8'($urandom_range(1, 255));
    return name_char();
  endfunction

  function automatic logic [63:0] pattern_word(int w);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) r[b * 8 +: 8] = pat_img[w * 8 + b];
    return r;
  endfunction

  function automatic void set_text(string s);
    foreach (pat_img[i]) pat_img[i] = 8'h00;
    foreach (s[i]) pat_img[i] = s[i];
  endfunction

  function automatic void build_name();
    int unsigned r;
    int unsigned n;
    int unsigned p;
    logic [7:0]  c;
    name_q.delete();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(0, 8)) name_q.push_back(name_char());
    end else if (r < 20) begin
      repeat ($urandom_range(28, 44)) name_q.push_back(name_char());
    end else begin
      n = (cfg_len > PAT_BYTES) ? PAT_BYTES : cfg_len;
      for (int unsigned i = 0; i < n; i++) begin
        c = pat_img[i];
        if (c == 8'h00) break;
        if (c == CH_STAR) begin
          repeat ($urandom_range(0, 3)) name_q.push_back(name_char());
        end else if (c == CH_QMARK) begin
          name_q.push_back(name_char());
        end else begin
          if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 3) == 0) begin
            c = c ^ 8'h20;
          end
          name_q.push_back(c);
        end
      end
      if ($urandom_range(0, 9) < 3) begin
        p = $urandom_range(0, name_q.size());
        case ($urandom_range(0, 2))
          0: name_q.insert(p, name_char());
          1: if (name_q.size() > 0) name_q.delete(p % name_q.size());
          default: if (name_q.size() > 0) name_q[p % name_q.size()] = name_char();
        endcase
      end
    end
    if ($urandom_range(0, 19) == 0) name_q.insert($urandom_range(0, name_q.size()), 8'h00);
    while (name_q.size() > NAME_MAX) void'(name_q.pop_back());
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] b);
    if (items_sent < QUIET_FROM && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= kind;
    in_tdata    <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind || b != 8'h00) items_sent++;
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_item(1'b0, name_q[i]);
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    name_q.delete();
    foreach (s[i]) name_q.push_back(s[i]);
    send_name();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_pattern(input int unsigned len, input bit fold);
    wait_drained();
    cfg_len  = len;
    write_reg(REG_PAT0, pattern_word(0));
    write_reg(REG_PAT1, pattern_word(1));
    write_reg(REG_PAT2, pattern_word(2));
    write_reg(REG_PAT3, pattern_word(3));
    write_reg(REG_LEN, CFG_W'(len));
    write_reg(REG_FOLD, CFG_W'(fold));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic make_random_pattern();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 19);
    foreach (pat_img[i]) pat_img[i] = pattern_char();
    if (r == 0) len = 0;
    else if (r == 1) len = 32;
    else if (r == 2) len = $urandom_range(33, 63);
    else if (r == 3) begin
      foreach (pat_img[i]) pat_img[i] = 8'hFF;
      len = 32;
    end else len = $urandom_range(1, 10);
    load_pattern(len, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    cfg_len  = 0;
    foreach (pat_img[i]) pat_img[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: an empty pattern with folding on.
    send_text("");
    name_q = {8'h01};
    send_name();
    name_q = {8'h00};
    send_name();

    set_text("a?*x*");
    load_pattern(5, 1'b1);
    send_text("AbQX9");

    set_text("*.c");
    load_pattern(3, 1'b0);
    name_q = {8'hFF, ".", "C"};
    send_name();

    foreach (pat_img[i]) pat_img[i] = "z";
    load_pattern(63, 1'b0);
    send_text("zz");

    set_text("ab");
    load_pattern(10, 1'b1);
    send_text("AB");

    set_text("ab*");
    load_pattern(3, 1'b1);
    send_text("ab");

    while (items_sent < ITEM_TARGET) begin
      make_random_pattern();
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 8;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 8;
        default: stall_pct = 35;
      endcase
      repeat ($urandom_range(4, 12)) begin
        build_name();
        send_name();
      end
    end

    wait_drained();
    $display("Sent %0d name and end transactions under %0d pattern settings.",
             items_sent, settings);
    $display("Checked %0d verdicts, %0d of them wrong or unexpected.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/wnm_pkg.sv
hw/rtl/wnm_cfg.sv
hw/rtl/wnm_core.sv
hw/rtl/wildcard_name_matcher_unit.sv
test/wildcard_name_matcher_unit_tb.sv
